FILE: design/adagc_pkg.sv
// shared types and constants for the attack/decay gain control block
// no dependencies; used by adagc_ctrl, adagc_dp and attack_decay_agc_top
`default_nettype none

package adagc_pkg;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 24;

   localparam logic [CSR_INDEX_W-1:0] CSR_DECAY_COEF   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ATTACK_COEF  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_REF_LEVEL    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_INITIAL_GAIN = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_GAIN     = 3'd4;

   localparam logic [15:0] DECAY_COEF_RST   = 16'd66;
   localparam logic [15:0] ATTACK_COEF_RST  = 16'd6554;
   localparam logic [14:0] REF_LEVEL_RST    = 15'd16384;
   localparam logic [23:0] INITIAL_GAIN_RST = 24'd65536;
   localparam logic [23:0] MAX_GAIN_RST     = 24'd0;

   localparam logic [23:0] GAIN_FLOOR = 24'd7;
   localparam logic [23:0] GAIN_CEIL  = 24'hFFFFFF;

   localparam int unsigned SQRT_STEPS = 16;
   localparam int unsigned SQRT_CNT_W = 4;

   typedef logic [3:0] op_type;

   localparam op_type OP_NONE     = 4'd0;
   localparam op_type OP_LOAD     = 4'd1;
   localparam op_type OP_MUL_IG   = 4'd2;
   localparam op_type OP_MUL_QG   = 4'd3;
   localparam op_type OP_MUL_II   = 4'd4;
   localparam op_type OP_MUL_QQ   = 4'd5;
   localparam op_type OP_MUL_OI   = 4'd6;
   localparam op_type OP_MUL_OQ   = 4'd7;
   localparam op_type OP_SQ_INIT  = 4'd8;
   localparam op_type OP_SQ_STEP  = 4'd9;
   localparam op_type OP_ERR      = 4'd10;
   localparam op_type OP_MUL_RATE = 4'd11;
   localparam op_type OP_COMMIT   = 4'd12;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

FILE: design/adagc_ctrl.sv
// sequencer for the gain control datapath: issues one operation per cycle
// while running and not held for a free result port; depends on adagc_pkg
`default_nettype none

module adagc_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire adagc_pkg::status_type status,
   output adagc_pkg::cmd_type        cmd
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_MI   = 4'd1;
   localparam logic [3:0] S_MQ   = 4'd2;
   localparam logic [3:0] S_PI   = 4'd3;
   localparam logic [3:0] S_PQ   = 4'd4;
   localparam logic [3:0] S_OI   = 4'd5;
   localparam logic [3:0] S_OQ   = 4'd6;
   localparam logic [3:0] S_SQ0  = 4'd7;
   localparam logic [3:0] S_SQRT = 4'd8;
   localparam logic [3:0] S_ERR  = 4'd9;
   localparam logic [3:0] S_RATE = 4'd10;
   localparam logic [3:0] S_DONE = 4'd11;

   localparam logic [adagc_pkg::SQRT_CNT_W-1:0] CNT_LAST =
      adagc_pkg::SQRT_CNT_W'(adagc_pkg::SQRT_STEPS - 1);

   logic [3:0]                        state_ff;
   logic [3:0]                        state_in;
   logic [adagc_pkg::SQRT_CNT_W-1:0]  cnt_ff;
   logic [adagc_pkg::SQRT_CNT_W-1:0]  cnt_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd.op   = adagc_pkg::OP_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = adagc_pkg::OP_LOAD;
               state_in = S_MI;
            end
         end
         S_MI: begin
            cmd.op   = adagc_pkg::OP_MUL_IG;
            state_in = S_MQ;
         end
         S_MQ: begin
            cmd.op   = adagc_pkg::OP_MUL_QG;
            state_in = S_PI;
         end
         S_PI: begin
            cmd.op   = adagc_pkg::OP_MUL_II;
            state_in = S_PQ;
         end
         S_PQ: begin
            cmd.op   = adagc_pkg::OP_MUL_QQ;
            state_in = S_OI;
         end
         S_OI: begin
            cmd.op   = adagc_pkg::OP_MUL_OI;
            state_in = S_OQ;
         end
         S_OQ: begin
            cmd.op   = adagc_pkg::OP_MUL_OQ;
            state_in = S_SQ0;
         end
         S_SQ0: begin
            cmd.op   = adagc_pkg::OP_SQ_INIT;
            cnt_in   = '0;
            state_in = S_SQRT;
         end
         S_SQRT: begin
            cmd.op = adagc_pkg::OP_SQ_STEP;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               state_in = S_ERR;
            end
         end
         S_ERR: begin
            cmd.op   = adagc_pkg::OP_ERR;
            state_in = S_RATE;
         end
         S_RATE: begin
            cmd.op   = adagc_pkg::OP_MUL_RATE;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (status.out_free) begin
               cmd.op   = adagc_pkg::OP_COMMIT;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

`ifndef SYNTHESIS
   a_sqrt_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ERR) |->
         ($past(state_ff, adagc_pkg::SQRT_STEPS) == S_SQRT &&
          $past(state_ff, adagc_pkg::SQRT_STEPS + 1) == S_SQ0))
      else $error("square root did not run its full step count");

   a_done_wait: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && !status.out_free) |=> (state_ff == S_DONE))
      else $error("left done state while result register busy");

   a_idle_accept: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && req_valid) |=> (state_ff == S_MI))
      else $error("transfer accepted without starting the sequence");
`endif

endmodule

`default_nettype wire

FILE: design/adagc_dp.sv
// datapath: config registers, gain state, shared multiplier, square root
// step unit, result register; depends on adagc_pkg
`default_nettype none

module adagc_dp (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire adagc_pkg::cmd_type                   cmd,
   output adagc_pkg::status_type                     status,
   input  wire logic                                 csr_we,
   input  wire logic [adagc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [adagc_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  wire logic signed [15:0]                   req_in_i,
   input  wire logic signed [15:0]                   req_in_q,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic signed [15:0]                        rsp_out_i,
   output logic signed [15:0]                        rsp_out_q,
   output logic [31:0]                               rsp_input_power,
   output logic [23:0]                               rsp_gain_used
);

   logic [15:0]        decay_coef_ff;
   logic [15:0]        attack_coef_ff;
   logic [14:0]        ref_level_ff;
   logic [23:0]        max_gain_ff;
   logic [23:0]        gain_ff;
   logic               rsp_valid_ff;

   logic signed [15:0] si_ff;
   logic signed [15:0] sq_ff;
   logic signed [41:0] prod_ff;
   logic signed [15:0] oi_ff;
   logic signed [15:0] oq_ff;
   logic [31:0]        pow_ff;
   logic [31:0]        sqx_ff;
   logic [31:0]        res_ff;
   logic [31:0]        bit_ff;
   logic signed [16:0] err_ff;
   logic signed [15:0] out_i_ff;
   logic signed [15:0] out_q_ff;
   logic [31:0]        out_pow_ff;
   logic [23:0]        out_gain_ff;

   logic signed [16:0] mul_a;
   logic signed [24:0] mul_b;
   logic               mul_en;
   logic signed [41:0] prod_in;
   logic [31:0]        trial;
   logic               attack_sel;
   logic [15:0]        rate_sel;
   logic signed [41:0] step_rnd;
   logic signed [41:0] step_full;
   logic signed [27:0] ng_raw;
   logic signed [27:0] ng_fix;
   logic [23:0]        gain_in;
   logic signed [16:0] err_in;

   function automatic logic signed [15:0] round_sat(input logic signed [41:0] p);
      logic signed [41:0] r;
      logic signed [41:0] t;
      r = p + 42'sd32768;
      t = r >>> 16;
      if (t > 42'sd32767) begin
         return 16'sh7FFF;
      end else if (t < -42'sd32768) begin
         return 16'sh8000;
      end
      return t[15:0];
   endfunction

   assign status.out_free = !rsp_valid_ff || rsp_ready;

   assign attack_sel = $signed({{8{err_ff[16]}}, err_ff, 1'b0}) > $signed({2'b00, gain_ff});
   assign rate_sel   = attack_sel ? attack_coef_ff : decay_coef_ff;

   always_comb begin
      mul_a  = '0;
      mul_b  = '0;
      mul_en = 1'b1;
      unique case (cmd.op)
         adagc_pkg::OP_MUL_IG: begin
            mul_a = 17'(si_ff);
            mul_b = $signed({1'b0, gain_ff});
         end
         adagc_pkg::OP_MUL_QG: begin
            mul_a = 17'(sq_ff);
            mul_b = $signed({1'b0, gain_ff});
         end
         adagc_pkg::OP_MUL_II: begin
            mul_a = 17'(si_ff);
            mul_b = 25'(si_ff);
         end
         adagc_pkg::OP_MUL_QQ: begin
            mul_a = 17'(sq_ff);
            mul_b = 25'(sq_ff);
         end
         adagc_pkg::OP_MUL_OI: begin
            mul_a = 17'(oi_ff);
            mul_b = 25'(oi_ff);
         end
         adagc_pkg::OP_MUL_OQ: begin
            mul_a = 17'(oq_ff);
            mul_b = 25'(oq_ff);
         end
         adagc_pkg::OP_MUL_RATE: begin
            mul_a = err_ff;
            mul_b = $signed({9'd0, rate_sel});
         end
         default: begin
            mul_en = 1'b0;
         end
      endcase
      prod_in = 42'(mul_a) * 42'(mul_b);
   end

   assign trial  = res_ff + bit_ff;
   assign err_in = $signed({1'b0, res_ff[15:0]}) - $signed({2'b00, ref_level_ff});

   // new gain from the registered error times rate product
   always_comb begin
      step_rnd  = prod_ff + 42'sd16384;
      step_full = step_rnd >>> 15;
      ng_raw    = $signed({4'd0, gain_ff}) - step_full[27:0];
      ng_fix    = ng_raw;
      if (ng_fix < 28'sd0) begin
         ng_fix = $signed({4'd0, adagc_pkg::GAIN_FLOOR});
      end
      if (max_gain_ff != '0 && ng_fix > $signed({4'd0, max_gain_ff})) begin
         ng_fix = $signed({4'd0, max_gain_ff});
      end
      if (ng_fix > $signed({4'd0, adagc_pkg::GAIN_CEIL})) begin
         ng_fix = $signed({4'd0, adagc_pkg::GAIN_CEIL});
      end
      gain_in = ng_fix[23:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         decay_coef_ff  <= adagc_pkg::DECAY_COEF_RST;
         attack_coef_ff <= adagc_pkg::ATTACK_COEF_RST;
         ref_level_ff   <= adagc_pkg::REF_LEVEL_RST;
         max_gain_ff    <= adagc_pkg::MAX_GAIN_RST;
         gain_ff        <= adagc_pkg::INITIAL_GAIN_RST;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               adagc_pkg::CSR_DECAY_COEF:   decay_coef_ff  <= csr_wdata[15:0];
               adagc_pkg::CSR_ATTACK_COEF:  attack_coef_ff <= csr_wdata[15:0];
               adagc_pkg::CSR_REF_LEVEL:    ref_level_ff   <= csr_wdata[14:0];
               adagc_pkg::CSR_INITIAL_GAIN: gain_ff        <= csr_wdata;
               adagc_pkg::CSR_MAX_GAIN:     max_gain_ff    <= csr_wdata;
               default: begin
               end
            endcase
         end
         if (cmd.op == adagc_pkg::OP_COMMIT) begin
            gain_ff      <= gain_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= prod_in;
      end
      unique case (cmd.op)
         adagc_pkg::OP_LOAD: begin
            si_ff <= req_in_i;
            sq_ff <= req_in_q;
         end
         adagc_pkg::OP_MUL_QG: oi_ff  <= round_sat(prod_ff);
         adagc_pkg::OP_MUL_II: oq_ff  <= round_sat(prod_ff);
         adagc_pkg::OP_MUL_QQ: pow_ff <= prod_ff[31:0];
         adagc_pkg::OP_MUL_OI: pow_ff <= pow_ff + prod_ff[31:0];
         adagc_pkg::OP_MUL_OQ: sqx_ff <= prod_ff[31:0];
         adagc_pkg::OP_SQ_INIT: begin
            sqx_ff <= sqx_ff + prod_ff[31:0];
            res_ff <= '0;
            bit_ff <= 32'h4000_0000;
         end
         adagc_pkg::OP_SQ_STEP: begin
            if (sqx_ff >= trial) begin
               sqx_ff <= sqx_ff - trial;
               res_ff <= (res_ff >> 1) + bit_ff;
            end else begin
               res_ff <= res_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
         end
         adagc_pkg::OP_ERR: err_ff <= err_in;
         adagc_pkg::OP_COMMIT: begin
            out_i_ff    <= oi_ff;
            out_q_ff    <= oq_ff;
            out_pow_ff  <= pow_ff;
            out_gain_ff <= gain_ff;
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_i       = out_i_ff;
   assign rsp_out_q       = out_q_ff;
   assign rsp_input_power = out_pow_ff;
   assign rsp_gain_used   = out_gain_ff;

`ifndef SYNTHESIS
   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == adagc_pkg::OP_COMMIT) |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten before transfer");

   a_commit_valid: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == adagc_pkg::OP_COMMIT) |=> rsp_valid_ff)
      else $error("committed result not presented");

   a_gain_hold: assert property (@(posedge clock) disable iff (reset)
      (cmd.op != adagc_pkg::OP_COMMIT &&
       !(csr_we && csr_index == adagc_pkg::CSR_INITIAL_GAIN)) |=> $stable(gain_ff))
      else $error("gain changed outside commit or initial gain write");

   a_mag_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == adagc_pkg::OP_ERR) |-> (res_ff[31:16] == 16'd0))
      else $error("magnitude out of range");
`endif

endmodule

`default_nettype wire

FILE: design/attack_decay_agc_top.sv
// top level of the attack/decay automatic gain control
// depends on adagc_pkg, adagc_ctrl and adagc_dp
`default_nettype none

// One complex sample in, one result out. Each sample is scaled by the Q8.16
// gain, rounded and saturated, and reported with its input power and the gain
// applied; the gain then moves by the magnitude error times the attack or decay
// rate. An item makes seven passes through the single shared 17x25 multiplier
// plus a 16-step bit-serial square root of the output power, and its result
// waits until the result port is free. The input port takes a new transfer as
// soon as the result is loaded into the output register, so a result may wait
// there while the next sample is being worked on. A write to initial_gain
// also loads the running gain.

module attack_decay_agc_top (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_we,
   input  wire logic [adagc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [adagc_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic signed [15:0]                 req_in_i,
   input  wire logic signed [15:0]                 req_in_q,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic signed [15:0]                      rsp_out_i,
   output logic signed [15:0]                      rsp_out_q,
   output logic [31:0]                             rsp_input_power,
   output logic [23:0]                             rsp_gain_used
);

   adagc_pkg::cmd_type    cmd;
   adagc_pkg::status_type status;

   adagc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   adagc_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_in_i        (req_in_i),
      .req_in_q        (req_in_q),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_i       (rsp_out_i),
      .rsp_out_q       (rsp_out_q),
      .rsp_input_power (rsp_input_power),
      .rsp_gain_used   (rsp_gain_used)
   );

endmodule

`default_nettype wire
